>>> design/v3a_pkg.sv
// ----------------------------------------------------------------------------
// v3a_pkg: shared types and constants of the 3D vector ALU
// Word layouts, opcodes, fixed-point constants and the 32-bit saturation.
// ----------------------------------------------------------------------------
package v3a_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int NEAR_ZERO_LSB = 7;
  localparam int DIV_W         = 32 + FRAC_BITS;
  localparam int SQRT_STEPS    = 32;

  localparam logic [31:0] ONE_Q     = 32'(1) << FRAC_BITS;
  localparam logic [31:0] NEAR_ZERO = 32'(NEAR_ZERO_LSB);
  localparam logic [31:0] SAT_MAX   = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN   = 32'h8000_0000;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_SCALE = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_DOT   = 3'd4;
  localparam logic [2:0] OP_CROSS = 3'd5;
  localparam logic [2:0] OP_MAG   = 3'd6;
  localparam logic [2:0] OP_NORM  = 3'd7;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scalar_in;
  } item_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_scalar;
  } result_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] scalar;
    result_t            res;
  } carry_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [DIV_W-1:0] num;
    logic [31:0]      rem;
    logic [DIV_W-1:0] quo;
    logic             neg;
  } lane_t;

  typedef struct packed {
    logic [31:0]     den;
    lane_t [2:0]     lane;
  } div_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v[65:31] == {35{v[65]}}) begin
      r = v[31:0];
    end else begin
      r = v[65] ? SAT_MIN : SAT_MAX;
    end
    return r;
  endfunction

endpackage

>>> design/v3a_front.sv
// ----------------------------------------------------------------------------
// v3a_front: input, multiply and sum stages
// Registers the word, forms up to six products, then sums, shifts and
// saturates them and hands the sum of squares on as the radicand.
// ----------------------------------------------------------------------------
module v3a_front
  import v3a_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        item_valid,
  input  item_t       item,
  output logic        valid,
  output carry_t      carry,
  output logic [63:0] rad
);

  logic               va, vb;
  item_t              ia, ib;
  logic signed [31:0] ml [3];
  logic signed [31:0] mr [3];
  logic signed [63:0] pb [6];
  logic signed [32:0] asb [3];
  logic signed [65:0] sum;
  result_t            res;

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      vb    <= 1'b0;
      valid <= 1'b0;
    end else if (adv) begin
      va    <= item_valid;
      vb    <= va;
      valid <= vb;
    end
  end

  always_comb begin
    ml[0] = ia.a_y; mr[0] = ia.b_z;
    ml[1] = ia.a_z; mr[1] = ia.b_y;
    ml[2] = ia.a_z; mr[2] = ia.b_x;
    unique case (ia.op)
      OP_SCALE: begin
        ml[0] = ia.a_x; ml[1] = ia.a_y; ml[2] = ia.a_z;
        mr[0] = ia.scalar_in; mr[1] = ia.scalar_in; mr[2] = ia.scalar_in;
      end
      OP_DOT: begin
        ml[0] = ia.a_x; ml[1] = ia.a_y; ml[2] = ia.a_z;
        mr[0] = ia.b_x; mr[1] = ia.b_y; mr[2] = ia.b_z;
      end
      OP_MAG, OP_NORM: begin
        ml[0] = ia.a_x; ml[1] = ia.a_y; ml[2] = ia.a_z;
        mr[0] = ia.a_x; mr[1] = ia.a_y; mr[2] = ia.a_z;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ia    <= item;
      ib    <= ia;
      pb[0] <= ml[0] * mr[0];
      pb[1] <= ml[1] * mr[1];
      pb[2] <= ml[2] * mr[2];
      pb[3] <= ia.a_x * ia.b_z;
      pb[4] <= ia.a_x * ia.b_y;
      pb[5] <= ia.a_y * ia.b_x;
      if (ia.op == OP_SUB) begin
        asb[0] <= 33'(ia.a_x) - 33'(ia.b_x);
        asb[1] <= 33'(ia.a_y) - 33'(ia.b_y);
        asb[2] <= 33'(ia.a_z) - 33'(ia.b_z);
      end else begin
        asb[0] <= 33'(ia.a_x) + 33'(ia.b_x);
        asb[1] <= 33'(ia.a_y) + 33'(ia.b_y);
        asb[2] <= 33'(ia.a_z) + 33'(ia.b_z);
      end
    end
  end

  assign sum = 66'(pb[0]) + 66'(pb[1]) + 66'(pb[2]);

  always_comb begin
    res = '0;
    unique case (ib.op)
      OP_ADD, OP_SUB: begin
        res.r_x = sat32(66'(asb[0]));
        res.r_y = sat32(66'(asb[1]));
        res.r_z = sat32(66'(asb[2]));
      end
      OP_SCALE: begin
        res.r_x = sat32(66'(pb[0]) >>> FRAC_BITS);
        res.r_y = sat32(66'(pb[1]) >>> FRAC_BITS);
        res.r_z = sat32(66'(pb[2]) >>> FRAC_BITS);
      end
      OP_DOT: begin
        res.r_scalar = sat32(sum >>> FRAC_BITS);
      end
      OP_CROSS: begin
        res.r_x = sat32((66'(pb[0]) - 66'(pb[1])) >>> FRAC_BITS);
        res.r_y = sat32((66'(pb[2]) - 66'(pb[3])) >>> FRAC_BITS);
        res.r_z = sat32((66'(pb[4]) - 66'(pb[5])) >>> FRAC_BITS);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      carry.op     <= ib.op;
      carry.a_x    <= ib.a_x;
      carry.a_y    <= ib.a_y;
      carry.a_z    <= ib.a_z;
      carry.scalar <= ib.scalar_in;
      carry.res    <= res;
      rad          <= sum[63:0];
    end
  end

endmodule

>>> design/v3a_sqrt_cell.sv
// ----------------------------------------------------------------------------
// v3a_sqrt_cell: one step of the bitwise square root
// Takes two radicand bits, decides one root bit, passes the word on.
// ----------------------------------------------------------------------------
module v3a_sqrt_cell
  import v3a_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   valid_i,
  input  carry_t carry_i,
  input  sqrt_t  st_i,
  output logic   valid_o,
  output carry_t carry_o,
  output sqrt_t  st_o
);

  logic [35:0] acc;
  logic [35:0] trial;
  logic        take;

  assign acc   = {st_i.rem, st_i.rad[63:62]};
  assign trial = {2'b00, st_i.root, 2'b01};
  assign take  = acc >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (adv) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      carry_o   <= carry_i;
      st_o.rad  <= {st_i.rad[61:0], 2'b00};
      st_o.rem  <= take ? 34'(acc - trial) : acc[33:0];
      st_o.root <= {st_i.root[30:0], take};
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    valid_o |-> (st_o.rem <= {1'b0, st_o.root, 1'b0}))
    else $error("square root remainder above twice the root");

endmodule

>>> design/v3a_div_cell.sv
// ----------------------------------------------------------------------------
// v3a_div_cell: one restoring division step on three lanes
// Shifts in one dividend bit per lane, decides one quotient bit each.
// ----------------------------------------------------------------------------
module v3a_div_cell
  import v3a_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   valid_i,
  input  carry_t carry_i,
  input  div_t   st_i,
  output logic   valid_o,
  output carry_t carry_o,
  output div_t   st_o
);

  logic [32:0] acc [3];
  logic        take [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i]  = {st_i.lane[i].rem, st_i.lane[i].num[DIV_W-1]};
      take[i] = acc[i] >= {1'b0, st_i.den};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (adv) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      carry_o  <= carry_i;
      st_o.den <= st_i.den;
      for (int i = 0; i < 3; i++) begin
        st_o.lane[i].num <= {st_i.lane[i].num[DIV_W-2:0], 1'b0};
        st_o.lane[i].rem <= take[i] ? 32'(acc[i] - {1'b0, st_i.den}) : acc[i][31:0];
        st_o.lane[i].quo <= {st_i.lane[i].quo[DIV_W-2:0], take[i]};
        st_o.lane[i].neg <= st_i.lane[i].neg;
      end
    end
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    valid_o |-> (st_o.lane[0].rem < st_o.den) && (st_o.lane[1].rem < st_o.den)
                && (st_o.lane[2].rem < st_o.den))
    else $error("division remainder not below divisor");

endmodule

>>> design/vector3_alu_top.sv
// ----------------------------------------------------------------------------
// vector3_alu_top: pipelined 3D vector ALU on Q16.16 components
// Add, subtract, scale, divide, dot, cross, magnitude and normalize.
// ----------------------------------------------------------------------------
// The unit takes one word per clock while item_stall is low and returns one
// result word per item, in order, through three front stages (input,
// multiply, sum), 32 square-root cells, one divisor stage, 48 divider cells
// (32 + FRAC_BITS) and the output register. Every op travels the full chain,
// so latency is the same for all. While a result is held by result_stall
// the whole chain holds and item_stall is raised.
module vector3_alu_top
  import v3a_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic   adv;
  logic   sv [SQRT_STEPS+1];
  carry_t sc [SQRT_STEPS+1];
  sqrt_t  ss [SQRT_STEPS+1];
  logic   dv [DIV_W+1];
  carry_t dc [DIV_W+1];
  div_t   ds [DIV_W+1];
  logic [63:0] frad;

  carry_t             pc_next;
  div_t               pd_next;
  carry_t             pc;
  div_t               pd;
  logic               pv;
  logic [31:0]        root;
  logic [31:0]        sabs;
  logic               dneg;
  logic signed [31:0] av [3];
  logic [31:0]        aabs;
  result_t            res;

  function automatic logic [31:0] qsat(input lane_t l);
    logic [31:0] r;
    if (l.quo[DIV_W-1:31] != '0) begin
      r = l.neg ? SAT_MIN : SAT_MAX;
    end else begin
      r = l.neg ? (~l.quo[31:0] + 32'd1) : l.quo[31:0];
    end
    return r;
  endfunction

  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;

  v3a_front u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item),
    .valid      (sv[0]),
    .carry      (sc[0]),
    .rad        (frad)
  );

  assign ss[0] = '{rad: frad, rem: '0, root: '0};

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    v3a_sqrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .valid_i (sv[g]),
      .carry_i (sc[g]),
      .st_i    (ss[g]),
      .valid_o (sv[g+1]),
      .carry_o (sc[g+1]),
      .st_o    (ss[g+1])
    );
  end

  always_comb begin
    pc_next = sc[SQRT_STEPS];
    root    = ss[SQRT_STEPS].root;
    sabs    = pc_next.scalar[31] ? (~pc_next.scalar + 32'd1) : pc_next.scalar;
    pd_next = '0;
    dneg    = 1'b0;
    if (pc_next.op == OP_DIV) begin
      if (sabs < NEAR_ZERO) begin
        pd_next.den = ONE_Q;
      end else begin
        pd_next.den = sabs;
        dneg        = pc_next.scalar[31];
      end
    end else begin
      pd_next.den = (root < NEAR_ZERO) ? ONE_Q : root;
    end
    if (pc_next.op == OP_MAG) begin
      pc_next.res.r_scalar = root[31] ? SAT_MAX : root;
    end
    av[0] = pc_next.a_x;
    av[1] = pc_next.a_y;
    av[2] = pc_next.a_z;
    for (int i = 0; i < 3; i++) begin
      aabs = av[i][31] ? (~av[i] + 32'd1) : av[i];
      pd_next.lane[i].num = {aabs, {FRAC_BITS{1'b0}}};
      pd_next.lane[i].neg = av[i][31] ^ dneg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (adv) begin
      pv <= sv[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pc <= pc_next;
      pd <= pd_next;
    end
  end

  assign dv[0] = pv;
  assign dc[0] = pc;
  assign ds[0] = pd;

  for (genvar g = 0; g < DIV_W; g++) begin : g_div
    v3a_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .valid_i (dv[g]),
      .carry_i (dc[g]),
      .st_i    (ds[g]),
      .valid_o (dv[g+1]),
      .carry_o (dc[g+1]),
      .st_o    (ds[g+1])
    );
  end

  always_comb begin
    res = dc[DIV_W].res;
    if (dc[DIV_W].op == OP_DIV || dc[DIV_W].op == OP_NORM) begin
      res.r_x = qsat(ds[DIV_W].lane[0]);
      res.r_y = qsat(ds[DIV_W].lane[1]);
      res.r_z = qsat(ds[DIV_W].lane[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= dv[DIV_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= res;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result word valid right after reset");

endmodule
